### rtl/core/dedup_set_table_macros.svh
// Assertion macros shared by the dedup set table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef DEDUP_SET_TABLE_MACROS_SVH
`define DEDUP_SET_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dedup_set_table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dedup_set_table: next-cycle check failed");

`endif

### rtl/core/dst_pkg.sv
// Shared types and constants for the dedup set table.
// No dependencies; imported by the engine and the top level.
package dst_pkg;

    localparam int CMD_W      = 2;
    localparam int VALUE_IN_W = 32;
    localparam int POS_W      = 7;
    localparam int FILL_W     = 8;
    localparam int ST_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2
    } t_command;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [FILL_W-1:0] fill_count;
        t_status           status;
    } t_result;

endpackage

### rtl/core/dst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/dst_engine.sv
// Search and compaction sequencer for the dedup set table; owns the fill count.
// Depends on dst_pkg and dedup_set_table_macros.svh; drives one dst_ram.
`include "dedup_set_table_macros.svh"

module dst_engine #(
    parameter int DEPTH       = 128,
    parameter int VALUE_WIDTH = 32,
    localparam int AW         = $clog2(DEPTH),
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  dst_pkg::t_command      i_command,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output dst_pkg::t_result       o_res,
    output logic [AW-1:0]          o_rd_addr,
    input  logic [VALUE_WIDTH-1:0] i_rd_data,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output logic [VALUE_WIDTH-1:0] o_wr_data
);
    import dst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_cnt;
    logic [AW-1:0]          r_idx;
    t_command               r_cmd;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_found;
    logic [POS_W-1:0]       r_pos;
    t_status                r_status;

    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_p2;
    logic          hit;
    logic          last;
    logic          full;

    always_comb begin
        idx_p1 = CW'(r_idx) + CW'(1);
        idx_p2 = CW'(r_idx) + CW'(2);
        hit    = (r_cnt != '0) && (i_rd_data == r_val);
        last   = (idx_p1 >= r_cnt);
        full   = (r_cnt == CW'(DEPTH));
    end

    // Memory port control: the read for the next entry is issued while the
    // current one is compared or moved.
    always_comb begin
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = i_rd_data;
        unique case (r_state)
            S_SEARCH: begin
                o_rd_addr = AW'(idx_p1);
                o_wr_en   = !hit && last && (r_cmd == CMD_INSERT) && !full;
                o_wr_addr = AW'(r_cnt);
                o_wr_data = r_val;
            end
            S_SHIFT: begin
                o_rd_addr = AW'(idx_p2);
                o_wr_en   = 1'b1;
            end
            default: begin
                o_rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_command;
                        r_val   <= i_value;
                        r_idx   <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_found <= 1'b1;
                        r_pos   <= POS_W'(r_idx);
                        unique case (r_cmd)
                            CMD_INSERT: begin
                                r_status <= ST_PRESENT;
                                r_state  <= S_DONE;
                            end
                            CMD_DELETE: begin
                                r_status <= ST_DONE;
                                if (last) begin
                                    r_cnt   <= r_cnt - CW'(1);
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SHIFT;
                                end
                            end
                            default: begin
                                r_status <= ST_DONE;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end else if (last) begin
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        r_state <= S_DONE;
                        if (r_cmd == CMD_INSERT) begin
                            if (full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_DONE;
                                r_cnt    <= r_cnt + CW'(1);
                            end
                        end else begin
                            r_status <= ST_ABSENT;
                        end
                    end else begin
                        r_idx <= AW'(idx_p1);
                    end
                end
                S_SHIFT: begin
                    if (idx_p2 >= r_cnt) begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= AW'(idx_p1);
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.found      = r_found;
        o_res.position   = r_pos;
        o_res.fill_count = FILL_W'(r_cnt);
        o_res.status     = r_status;
    end

    `DST_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH))
    `DST_ASSERT_IMPL(a_shift_range, i_clk, i_rst_n, r_state == S_SHIFT, idx_p1 < r_cnt)
    `DST_ASSERT_NEXT(a_cnt_hold_idle, i_clk, i_rst_n, r_state == S_IDLE, r_cnt == $past(r_cnt))
    `DST_ASSERT_IMPL(a_wr_state, i_clk, i_rst_n, o_wr_en, r_state == S_SEARCH || r_state == S_SHIFT)

endmodule

### rtl/core/dedup_set_table.sv
// Top level of the dedup set table: memory, sequencer and output register.
// Depends on dst_pkg, dst_ram and dst_engine.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_ready   i_command, i_value
//   result    out        o_out_valid / i_out_ready o_found, o_position,
//                                                  o_fill_count, o_status
//
// The sequencer compares the stored entries in order from position zero: the
// match position plus one of them, or the fill count on a miss, and at least
// one; a delete then moves each entry after the match down one place. The
// single read port of the entry memory sets this pace: one entry per cycle.
// Reset clears the fill count and the control state; the memory is not
// cleared, since only entries below the fill count are ever read.
// A waiting result in the output register does not stall the next item;
// the sequencer only holds when a second result is ready before the first
// has been taken.
module dedup_set_table #(
    parameter int DEPTH       = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [dst_pkg::CMD_W-1:0]            i_command,
    input  logic signed [dst_pkg::VALUE_IN_W-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_found,
    output logic [dst_pkg::POS_W-1:0]            o_position,
    output logic [dst_pkg::FILL_W-1:0]           o_fill_count,
    output logic [dst_pkg::ST_W-1:0]             o_status
);
    import dst_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH-1:0] value_cmp;
    logic                   res_valid;
    logic                   res_ready;
    t_result                res;

    logic                   r_out_valid;
    t_result                r_out;

    // Values compare on their low VALUE_WIDTH bits; a wider table sign-extends.
    assign value_cmp = VALUE_WIDTH'(i_value);

    dst_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dst_engine #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_command   (t_command'(i_command)),
        .i_value     (value_cmp),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // The output register takes a new result when it is empty or its
    // current result is transferred in the same cycle.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out.found;
    assign o_position   = r_out.position;
    assign o_fill_count = r_out.fill_count;
    assign o_status     = r_out.status;

endmodule

### tb/tb_dedup_set_table.sv
// Self-checking testbench for the dedup set table: directed rows, then random traffic.
// Depends on dst_pkg and the dedup_set_table RTL. Expected results come from the
// directed rows or from an in-bench model of the packed set.
module tb_dedup_set_table;
    import dst_pkg::*;

    // Command code 3 has no meaning of its own. The block must treat it as a lookup.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SET_DEPTH  = 128;
    localparam int POOL_SIZE  = 160;
    localparam int HOLD_AFTER = 40;   // results seen before the long receiver hold
    localparam int HOLD_LEN   = 400;  // cycles of that hold
    localparam int DRAIN_WAIT = 300;  // longer than a delete that shifts a full table
    localparam int N_ROWS     = 22;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [CMD_W-1:0]       i_command = '0;
    logic [VALUE_IN_W-1:0]  i_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_found;
    logic [POS_W-1:0]       o_position;
    logic [FILL_W-1:0]      o_fill_count;
    logic [ST_W-1:0]        o_status;

    // One row of the directed table. When typed is set, the expected result is the
    // one written in the row. Otherwise the set model supplies it.
    typedef struct {
        logic [CMD_W-1:0]      cmd;
        logic [VALUE_IN_W-1:0] val;
        bit                    typed;
        logic                  found;
        logic [POS_W-1:0]      pos;
        logic [FILL_W-1:0]     fill;
        t_status               status;
    } t_stim_row;

    // Model of the packed table: index i holds the value at position i.
    logic [VALUE_IN_W-1:0] set_words[$];
    // Results still owed by the block, oldest first.
    t_result               pending_results[$];
    logic [VALUE_IN_W-1:0] value_pool[POOL_SIZE];
    t_stim_row             directed_rows[N_ROWS];

    int mismatch_count = 0;
    int results_seen   = 0;
    bit no_idle        = 1'b0;

    dedup_set_table #(
        .DEPTH      (SET_DEPTH),
        .VALUE_WIDTH(VALUE_IN_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_fill_count(o_fill_count),
        .o_status    (o_status)
    );

    always #10 i_clk = ~i_clk;

    // Applies one command to the set model and returns the result the block owes.
    // The search finds the first match. An insert appends only absent values and
    // refuses when the table is full. A delete closes the gap, which is the
    // queue's own delete here.
    function automatic t_result apply_set_op(input logic [CMD_W-1:0] cmd,
                                             input logic [VALUE_IN_W-1:0] val);
        t_result r;
        int      hit;
        hit = -1;
        for (int i = 0; i < set_words.size(); i++) begin
            if (set_words[i] == val) begin
                hit = i;
                break;
            end
        end
        r.found    = (hit >= 0);
        r.position = (hit >= 0) ? POS_W'(hit) : '0;
        case (cmd)
            CMD_INSERT: begin
                if (hit >= 0) begin
                    r.status = ST_PRESENT;
                end else if (set_words.size() >= SET_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    set_words.push_back(val);
                    r.status = ST_DONE;
                end
            end
            CMD_DELETE: begin
                if (hit >= 0) begin
                    set_words.delete(hit);
                    r.status = ST_DONE;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            default: begin
                r.status = (hit >= 0) ? ST_DONE : ST_ABSENT;
            end
        endcase
        r.fill_count = FILL_W'(set_words.size());
        return r;
    endfunction

    // Chooses a command. The percentages are for insert, delete and lookup; the
    // rest goes to the unused code.
    function automatic logic [CMD_W-1:0] pick_command(input int ins_pct, input int del_pct,
                                                      input int look_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) return CMD_INSERT;
        if (r < ins_pct + del_pct) return CMD_DELETE;
        if (r < ins_pct + del_pct + look_pct) return CMD_LOOKUP;
        return CMD_UNUSED;
    endfunction

    // Half of the deletes and lookups aim at stored values, so many of them hit.
    // Inserts draw from a bounded pool, so duplicates are common and the table fills.
    function automatic logic [VALUE_IN_W-1:0] pick_value(input logic [CMD_W-1:0] cmd);
        int r;
        r = $urandom_range(0, 99);
        if (cmd != CMD_INSERT && set_words.size() > 0 && r < 50)
            return set_words[$urandom_range(0, set_words.size() - 1)];
        if (r < 80) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Offers one item and holds it until the transfer, then runs the model.
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_IN_W-1:0] val,
                              output t_result predicted);
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = apply_set_op(cmd, val);
    endtask

    // Now and then, unless no_idle is set, the sender drops valid for a random burst.
    task automatic maybe_pause_sender();
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Random phase: each item gets a command from the mix and a value, and the
    // model's result becomes the expectation.
    task automatic run_random(input int count, input int ins_pct, input int del_pct,
                              input int look_pct);
        logic [CMD_W-1:0] cmd;
        t_result          predicted;
        repeat (count) begin
            maybe_pause_sender();
            cmd = pick_command(ins_pct, del_pct, look_pct);
            offer_item(cmd, pick_value(cmd), predicted);
            pending_results.push_back(predicted);
        end
    endtask

    // Sender: reset, directed table, then three random phases.
    initial begin : stimulus
        t_result predicted;
        t_result typed_result;

        // Values at the extremes and alternating bit patterns.
        directed_rows = '{
            // An empty table: nothing is found.
            '{CMD_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 7'd0, 8'd0, ST_ABSENT},
            '{CMD_DELETE, 32'h8000_0000, 1'b1, 1'b0, 7'd0, 8'd0, ST_ABSENT},
            '{CMD_UNUSED, 32'h0000_0005, 1'b1, 1'b0, 7'd0, 8'd0, ST_ABSENT},
            // Fill with the most negative, the most positive, zero and minus one.
            '{CMD_INSERT, 32'h8000_0000, 1'b1, 1'b0, 7'd0, 8'd1, ST_DONE},
            '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 7'd0, 8'd2, ST_DONE},
            '{CMD_INSERT, 32'h0000_0000, 1'b1, 1'b0, 7'd0, 8'd3, ST_DONE},
            '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0, 8'd4, ST_DONE},
            // Duplicates are refused, and the position of the match is reported.
            '{CMD_INSERT, 32'h8000_0000, 1'b1, 1'b1, 7'd0, 8'd4, ST_PRESENT},
            '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd3, 8'd4, ST_PRESENT},
            '{CMD_LOOKUP, 32'h7FFF_FFFF, 1'b1, 1'b1, 7'd1, 8'd4, ST_DONE},
            '{CMD_UNUSED, 32'h0000_0000, 1'b1, 1'b1, 7'd2, 8'd4, ST_DONE},
            // Deleting the head moves every later entry down one place.
            '{CMD_DELETE, 32'h8000_0000, 1'b1, 1'b1, 7'd0, 8'd3, ST_DONE},
            '{CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd2, 8'd3, ST_DONE},
            // Deleting the tail moves nothing. A second delete misses.
            '{CMD_DELETE, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd2, 8'd2, ST_DONE},
            '{CMD_DELETE, 32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0, 8'd2, ST_ABSENT},
            '{CMD_INSERT, 32'h5555_5555, 1'b1, 1'b0, 7'd0, 8'd3, ST_DONE},
            '{CMD_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b0, 7'd0, 8'd4, ST_DONE},
            '{CMD_LOOKUP, 32'hAAAA_AAAA, 1'b1, 1'b1, 7'd3, 8'd4, ST_DONE},
            '{CMD_DELETE, 32'h7FFF_FFFF, 1'b1, 1'b1, 7'd0, 8'd3, ST_DONE},
            '{CMD_LOOKUP, 32'h5555_5555, 1'b1, 1'b1, 7'd1, 8'd3, ST_DONE},
            '{CMD_INSERT, 32'h0000_0001, 1'b0, 1'b0, 7'd0, 8'd0, ST_DONE},
            '{CMD_DELETE, 32'h0000_0000, 1'b0, 1'b0, 7'd0, 8'd0, ST_DONE}
        };

        for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            maybe_pause_sender();
            offer_item(directed_rows[i].cmd, directed_rows[i].val, predicted);
            if (directed_rows[i].typed) begin
                typed_result.found      = directed_rows[i].found;
                typed_result.position   = directed_rows[i].pos;
                typed_result.fill_count = directed_rows[i].fill;
                typed_result.status     = directed_rows[i].status;
                pending_results.push_back(typed_result);
            end else begin
                pending_results.push_back(predicted);
            end
        end

        // Insert-heavy traffic fills the table, so that later inserts hit the full
        // case. Delete-heavy traffic then shifts long runs of entries. The last
        // part mixes everything with no idling on either side.
        run_random(300, 80, 8, 8);
        run_random(130, 20, 55, 20);
        no_idle = 1'b1;
        run_random(90, 35, 30, 30);
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: ready drops in random bursts. Once, it drops for a long stretch
    // while the sender keeps offering items, so the output register fills and the
    // input stalls.
    initial begin : result_sink
        bit long_hold_done;
        long_hold_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Each result transfer is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    mismatch_count++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    mismatch_count++;
                end
                if (o_fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, got %0d", want.fill_count,
                           o_fill_count);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin : watchdog
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### dedup_set_table.f
+incdir+rtl/core
rtl/core/dst_pkg.sv
rtl/core/dst_ram.sv
rtl/core/dst_engine.sv
rtl/core/dedup_set_table.sv
tb/tb_dedup_set_table.sv
